>>> hw/rtl/rgbhsl_pkg.sv
`default_nettype none
package rgbhsl_pkg;

    localparam int PIX_W      = 15;
    localparam int DS_W       = 8;
    localparam int MODE_W     = 2;
    localparam int DEN_W      = 18;
    localparam int NUM_W      = 34;
    localparam int DIV_STAGES = PIX_W;

    localparam logic [DS_W-1:0]   SCALE_MAX  = DS_W'(128);
    localparam logic [DS_W-1:0]   SCALE_RST  = DS_W'(1);
    localparam logic [MODE_W-1:0] MODE_HUE   = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_SAT   = MODE_W'(1);

    // one division in flight: partial remainder, divisor, quotient so far
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [PIX_W-1:0] quo;
    } div_slot_t;

    typedef struct packed {
        div_slot_t         hue;
        div_slot_t         sat;
        logic              gray;
        logic [PIX_W-1:0]  lit;
        logic [MODE_W-1:0] mode;
    } div_item_t;

    // one restoring step producing quotient bit 'pos'
    function automatic div_slot_t div_step(input div_slot_t s, input int pos);
        logic [NUM_W-1:0] shifted;
        div_slot_t        o;
        shifted = NUM_W'(s.den) << pos;
        o = s;
        if (s.rem >= shifted)
        begin
            o.rem = s.rem - shifted;
            o.quo = s.quo | (PIX_W'(1) << pos);
        end
        return o;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/rgbhsl_if.sv
`default_nettype none
interface pix_in_if;
    import rgbhsl_pkg::*;
    logic              valid;
    logic              ready;
    logic [PIX_W-1:0]  red;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  blue;
    logic [MODE_W-1:0] mode;
    modport source (output valid, red, green, blue, mode, input ready);
    modport sink   (input valid, red, green, blue, mode, output ready);
endinterface

interface hsl_out_if;
    import rgbhsl_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] hue;
    logic [PIX_W-1:0] saturation;
    logic [PIX_W-1:0] lightness;
    logic [PIX_W-1:0] selected;
    modport source (output valid, hue, saturation, lightness, selected, input ready);
    modport sink   (input valid, hue, saturation, lightness, selected, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/rgbhsl_front.sv
`default_nettype none
module rgbhsl_front
    import rgbhsl_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [DS_W-1:0] depth_scale,
    pix_in_if.sink               pixel,
    output logic                 item_valid,
    input  wire logic            item_ready,
    output div_item_t            item
);

    // stage A: clamp
    logic              a_valid_reg;
    logic [PIX_W-1:0]  a_r_reg, a_g_reg, a_b_reg, a_full_reg;
    logic [MODE_W-1:0] a_mode_reg;
    // stage B: extremes, lightness, hue numerator and both divisors
    logic              b_valid_reg;
    logic [PIX_W-1:0]  b_full_reg, b_d_reg, b_lit_reg;
    logic [DEN_W-1:0]  b_hnum_reg, b_hden_reg, b_sden_reg;
    logic              b_gray_reg;
    logic [MODE_W-1:0] b_mode_reg;
    // stage C: products
    logic              c_valid_reg;
    div_item_t         c_item_reg;

    logic a_adv, b_adv, c_adv;
    assign c_adv = !c_valid_reg || item_ready;
    assign b_adv = !b_valid_reg || c_adv;
    assign a_adv = !a_valid_reg || b_adv;
    assign pixel.ready = a_adv;

    logic [DS_W-1:0]  ds;
    logic [PIX_W-1:0] full;
    always_comb
    begin
        ds = depth_scale;
        if (ds == '0)
            ds = SCALE_RST;
        if (ds > SCALE_MAX)
            ds = SCALE_MAX;
        full = PIX_W'({ds, 8'b0} - {8'b0, ds});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_adv)
                a_valid_reg <= pixel.valid;
            if (b_adv)
                b_valid_reg <= a_valid_reg;
            if (c_adv)
                c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            a_r_reg    <= (pixel.red   > full) ? full : pixel.red;
            a_g_reg    <= (pixel.green > full) ? full : pixel.green;
            a_b_reg    <= (pixel.blue  > full) ? full : pixel.blue;
            a_full_reg <= full;
            a_mode_reg <= pixel.mode;
        end
    end

    logic [PIX_W-1:0] mx, mn, d;
    logic [PIX_W:0]   sum;
    logic [DEN_W-1:0] hnum_next;
    always_comb
    begin
        mx = a_b_reg;
        mn = a_b_reg;
        if (a_r_reg > mx) mx = a_r_reg;
        if (a_g_reg > mx) mx = a_g_reg;
        if (a_r_reg < mn) mn = a_r_reg;
        if (a_g_reg < mn) mn = a_g_reg;
        d   = mx - mn;
        sum = {1'b0, mx} + {1'b0, mn};
        // sector offsets 0, 2d, 4d; result is below 6d for any non-gray pixel
        if (a_r_reg == mx)
        begin
            if (a_g_reg >= a_b_reg)
                hnum_next = DEN_W'(a_g_reg - a_b_reg);
            else
                hnum_next = DEN_W'(6) * DEN_W'(d) - DEN_W'(a_b_reg - a_g_reg);
        end
        else if (a_g_reg == mx)
            hnum_next = (DEN_W'(d) << 1) + DEN_W'(a_b_reg) - DEN_W'(a_r_reg);
        else
            hnum_next = (DEN_W'(d) << 2) + DEN_W'(a_r_reg) - DEN_W'(a_g_reg);
    end

    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            b_full_reg <= a_full_reg;
            b_d_reg    <= d;
            b_lit_reg  <= sum[PIX_W:1];
            b_gray_reg <= (mx == mn);
            b_hnum_reg <= hnum_next;
            b_hden_reg <= DEN_W'(6) * DEN_W'(d);
            if (sum < {1'b0, a_full_reg})
                b_sden_reg <= DEN_W'(sum);
            else
                b_sden_reg <= DEN_W'({a_full_reg, 1'b0} - sum);
            b_mode_reg <= a_mode_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_adv)
        begin
            c_item_reg.hue.rem <= NUM_W'(b_full_reg) * NUM_W'(b_hnum_reg);
            c_item_reg.hue.den <= b_hden_reg;
            c_item_reg.hue.quo <= '0;
            c_item_reg.sat.rem <= NUM_W'(b_full_reg) * NUM_W'(b_d_reg);
            c_item_reg.sat.den <= b_sden_reg;
            c_item_reg.sat.quo <= '0;
            c_item_reg.gray    <= b_gray_reg;
            c_item_reg.lit     <= b_lit_reg;
            c_item_reg.mode    <= b_mode_reg;
        end
    end

    assign item_valid = c_valid_reg;
    assign item       = c_item_reg;

endmodule
`default_nettype wire

>>> hw/rtl/rgbhsl_div_pipe.sv
`default_nettype none
module rgbhsl_div_pipe
    import rgbhsl_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  div_item_t      in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output div_item_t      out_item
);

    // one quotient bit of both divisions per stage, MSB first
    logic      valid_reg [DIV_STAGES];
    div_item_t item_reg  [DIV_STAGES];
    logic      adv       [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_stage
            logic      prev_valid;
            div_item_t prev_item;
            div_item_t step;

            if (k == 0)
            begin : g_first
                assign prev_valid = in_valid;
                assign prev_item  = in_item;
            end
            else
            begin : g_rest
                assign prev_valid = valid_reg[k-1];
                assign prev_item  = item_reg[k-1];
            end

            if (k == DIV_STAGES-1)
            begin : g_last
                assign adv[k] = !valid_reg[k] || out_ready;
            end
            else
            begin : g_mid
                assign adv[k] = !valid_reg[k] || adv[k+1];
            end

            always_comb
            begin
                step     = prev_item;
                step.hue = div_step(prev_item.hue, DIV_STAGES-1-k);
                step.sat = div_step(prev_item.sat, DIV_STAGES-1-k);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[k] <= 1'b0;
                else if (adv[k])
                    valid_reg[k] <= prev_valid;
            end

            always_ff @(posedge clk)
            begin
                if (adv[k])
                    item_reg[k] <= step;
            end
        end
    endgenerate

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_item  = item_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

>>> hw/rtl/rgb_to_hsl_converter_core.sv
// RGB to HSL converter, one pixel per clock while result.ready stays high.
// Channels: 'pixel' (sink) carries red, green, blue and mode; 'result'
// (source) carries hue, saturation, lightness and selected. A transaction
// completes on a rising edge with valid and ready both high.
// Configuration: cfg_wr_en/cfg_wr_data write depth_scale (full scale is
// 255*depth_scale; 0 acts as 1, values above 128 as 128). Write only while
// the pipeline is empty.
// Pipeline: three front stages, fifteen divider stages, one output
// register.
// Throughput: one pixel per cycle while result.ready stays high; the divider
// spends one quotient bit per stage, so its depth follows the 15-bit result width.
// Reset: rst_n is asynchronous; all stage valid bits clear and depth_scale
// returns to 1.
// Stall: when result.ready is low, stages fill up behind the output
// register; bubbles are squeezed out and pixel.ready drops only once every
// stage holds a pixel. Nothing is dropped or repeated.
`default_nettype none
module rgb_to_hsl_converter_core
    import rgbhsl_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_wr_en,
    input  wire logic [DS_W-1:0] cfg_wr_data,
    pix_in_if.sink               pixel,
    hsl_out_if.source            result
);

    logic [DS_W-1:0] depth_scale_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            depth_scale_reg <= SCALE_RST;
        else if (cfg_wr_en)
            depth_scale_reg <= cfg_wr_data;
    end

    logic      f_valid, f_ready, d_valid, d_ready;
    div_item_t f_item, d_item;

    rgbhsl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .depth_scale (depth_scale_reg),
        .pixel       (pixel),
        .item_valid  (f_valid),
        .item_ready  (f_ready),
        .item        (f_item)
    );

    rgbhsl_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_item  (d_item)
    );

    logic             out_valid_reg;
    logic [PIX_W-1:0] hue_reg, sat_reg, lit_reg, sel_reg;
    logic [PIX_W-1:0] hue_next, sat_next;
    logic             out_adv;

    assign out_adv = !out_valid_reg || result.ready;
    assign d_ready = out_adv;

    // gray pixel: the hue divisor is zero, and the saturation divisor can be, so the quotients are junk
    assign hue_next = d_item.gray ? '0 : d_item.hue.quo;
    assign sat_next = d_item.gray ? '0 : d_item.sat.quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_adv)
            out_valid_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            lit_reg <= d_item.lit;
            case (d_item.mode)
                MODE_HUE: sel_reg <= hue_next;
                MODE_SAT: sel_reg <= sat_next;
                default:  sel_reg <= d_item.lit;
            endcase
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.hue        = hue_reg;
    assign result.saturation = sat_reg;
    assign result.lightness  = lit_reg;
    assign result.selected   = sel_reg;

endmodule
`default_nettype wire

>>> hw/rtl/rgbhsl_checker.sv
`default_nettype none
module rgbhsl_checker
    import rgbhsl_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire logic [PIX_W-1:0] hue,
    input wire logic [PIX_W-1:0] saturation,
    input wire logic [PIX_W-1:0] lightness,
    input wire logic [PIX_W-1:0] selected
);

    localparam logic [PIX_W-1:0] FULL_MAX = PIX_W'(32640);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped under stall");

    a_sel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (selected == hue || selected == saturation
                       || selected == lightness))
        else $error("selected matches no component");

    a_hue_rng: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hue < FULL_MAX)
        else $error("hue beyond full scale");

    a_rng: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (saturation <= FULL_MAX && lightness <= FULL_MAX))
        else $error("saturation or lightness beyond full scale");

endmodule

bind rgb_to_hsl_converter_core rgbhsl_checker u_rgbhsl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .hue        (result.hue),
    .saturation (result.saturation),
    .lightness  (result.lightness),
    .selected   (result.selected)
);
`default_nettype wire

>>> tb/rgb_to_hsl_converter_core_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module rgb_to_hsl_converter_core_tb;
    import rgbhsl_pkg::*;

    localparam int LATENCY   = 19;
    localparam int CYCLE_CAP = 200000;
    localparam int N_RANDOM  = 650;

    typedef struct packed {
        logic [PIX_W-1:0] hue;
        logic [PIX_W-1:0] sat;
        logic [PIX_W-1:0] lit;
        logic [PIX_W-1:0] sel;
    } hsl_t;

    typedef struct {
        logic [PIX_W-1:0]  r;
        logic [PIX_W-1:0]  g;
        logic [PIX_W-1:0]  b;
        logic [MODE_W-1:0] mode;
        bit                fixed;
        hsl_t              want;
    } pix_row_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [DS_W-1:0] cfg_wr_data;

    pix_in_if  pix_ch();
    hsl_out_if hsl_ch();

    rgb_to_hsl_converter_core DUT (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .pixel(pix_ch.sink), .result(hsl_ch.source)
    );

    logic [DS_W-1:0] scale_reg;
    hsl_t  hsl_expected[$];
    int    mismatches = 0;
    int    pixels_sent = 0;
    int    results_seen = 0;
    longint cycles = 0;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic hsl_t convert_pixel(logic [PIX_W-1:0] ri, logic [PIX_W-1:0] gi,
                                           logic [PIX_W-1:0] bi, logic [MODE_W-1:0] mode);
        longint ds, fs, r, g, b, mx, mn, d, sum, num, h, s, l;
        hsl_t o;
        ds = scale_reg;
        if (ds == 0) ds = 1;
        if (ds > SCALE_MAX) ds = SCALE_MAX;
        fs = 255 * ds;
        r = (ri > fs) ? fs : ri;
        g = (gi > fs) ? fs : gi;
        b = (bi > fs) ? fs : bi;
        mx = b; mn = b;
        if (r > mx) mx = r;
        if (g > mx) mx = g;
        if (r < mn) mn = r;
        if (g < mn) mn = g;
        sum = mx + mn;
        l = sum / 2;
        if (mx == mn)
        begin
            h = 0; s = 0;
        end
        else
        begin
            d = mx - mn;
            s = (sum < fs) ? (fs * d) / sum : (fs * d) / (2 * fs - sum);
            if (r == mx) num = (g >= b) ? g - b : 6 * d - (b - g);
            else if (g == mx) num = 2 * d + b - r;
            else num = 4 * d + r - g;
            h = (fs * num) / (6 * d);
        end
        o.hue = PIX_W'(h);
        o.sat = PIX_W'(s);
        o.lit = PIX_W'(l);
        o.sel = (mode == MODE_HUE) ? o.hue : (mode == MODE_SAT) ? o.sat : o.lit;
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch result %0d %s: got %0d want %0d", results_seen, what, got, want);
        mismatches++;
    endtask

    // result side: random stalls, compare against oldest expectation
    initial
    begin
        int gap;
        hsl_t w;
        hsl_ch.ready = 0;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                hsl_ch.ready <= 0;
                repeat (gap) @(posedge clk);
            end
            hsl_ch.ready <= 1;
            do @(posedge clk); while (!hsl_ch.valid);
            if (hsl_expected.size() == 0)
                report_mismatch("unexpected hue", hsl_ch.hue, 0);
            else
            begin
                w = hsl_expected.pop_front();
                if (hsl_ch.hue !== w.hue) report_mismatch("hue", hsl_ch.hue, w.hue);
                if (hsl_ch.saturation !== w.sat)
                    report_mismatch("saturation", hsl_ch.saturation, w.sat);
                if (hsl_ch.lightness !== w.lit)
                    report_mismatch("lightness", hsl_ch.lightness, w.lit);
                if (hsl_ch.selected !== w.sel)
                    report_mismatch("selected", hsl_ch.selected, w.sel);
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("rgb_to_hsl_converter_core regression: fail");
            $finish;
        end
    end

    task automatic send_pixel(pix_row_t row, bit burst);
        int gap;
        hsl_t w;
        gap = burst ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            pix_ch.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        w = row.fixed ? row.want : convert_pixel(row.r, row.g, row.b, row.mode);
        pix_ch.valid <= 1;
        pix_ch.red <= row.r;
        pix_ch.green <= row.g;
        pix_ch.blue <= row.b;
        pix_ch.mode <= row.mode;
        do @(posedge clk); while (!pix_ch.ready);
        hsl_expected.push_back(w);
        pixels_sent++;
    endtask

    task automatic set_scale(logic [DS_W-1:0] v);
        pix_ch.valid <= 0;
        wait (hsl_expected.size() == 0);
        repeat (LATENCY + 2) @(posedge clk);
        cfg_wr_en <= 1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 0;
        scale_reg = v;
    endtask

    function automatic pix_row_t rand_row(int fs);
        pix_row_t p;
        int lim;
        lim = ($urandom_range(0, 9) == 0) ? 32767 : fs;
        p.r = PIX_W'($urandom_range(0, lim));
        p.g = PIX_W'($urandom_range(0, lim));
        p.b = PIX_W'($urandom_range(0, lim));
        case ($urandom_range(0, 5))
            0: p.g = p.r;
            1: p.b = p.r;
            2: begin p.g = p.r; p.b = p.r; end
            default: ;
        endcase
        p.mode = MODE_W'($urandom_range(0, 3));
        p.fixed = 0;
        return p;
    endfunction

    initial
    begin
        pix_row_t directed[$];
        logic [DS_W-1:0] scales[$];
        int fs, ds;
        bit burst;
        directed = '{
            '{0, 0, 0, 0, 1, '{0, 0, 0, 0}},
            '{255, 255, 255, 2, 1, '{0, 0, 255, 255}},
            '{255, 0, 0, 0, 1, '{0, 255, 127, 0}},
            '{0, 255, 0, 0, 1, '{85, 255, 127, 85}},
            '{0, 0, 255, 1, 1, '{170, 255, 127, 255}},
            '{32767, 32767, 32767, 3, 1, '{0, 0, 255, 255}},
            '{32767, 0, 0, 3, 1, '{0, 255, 127, 127}},
            '{255, 0, 1, 0, 0, '{0, 0, 0, 0}},
            '{255, 1, 0, 0, 0, '{0, 0, 0, 0}},
            '{255, 255, 0, 0, 0, '{0, 0, 0, 0}},
            '{0, 255, 255, 0, 0, '{0, 0, 0, 0}},
            '{255, 0, 255, 0, 0, '{0, 0, 0, 0}},
            '{200, 100, 50, 1, 0, '{0, 0, 0, 0}},
            '{10, 20, 30, 2, 0, '{0, 0, 0, 0}},
            '{128, 127, 127, 1, 0, '{0, 0, 0, 0}},
            '{21845, 10922, 5461, 0, 0, '{0, 0, 0, 0}},
            '{16383, 16384, 8191, 1, 0, '{0, 0, 0, 0}}
        };
        // zero acts as 1, above 128 saturates
        scales = '{8'd1, 8'd128, 8'd0, 8'd255, 8'd3, 8'd64, 8'd129, 8'd17};
        rst_n = 0;
        cfg_wr_en = 0;
        cfg_wr_data = 0;
        pix_ch.valid = 0;
        pix_ch.red = 0;
        pix_ch.green = 0;
        pix_ch.blue = 0;
        pix_ch.mode = 0;
        scale_reg = SCALE_RST;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        foreach (directed[i]) send_pixel(directed[i], 0);
        set_scale(8'd128);
        foreach (directed[i])
        begin
            directed[i].fixed = 0;
            send_pixel(directed[i], 0);
        end
        foreach (scales[k])
        begin
            set_scale(scales[k]);
            ds = (scales[k] == 0) ? 1 : (scales[k] > 128) ? 128 : scales[k];
            fs = 255 * ds;
            for (int i = 0; i < N_RANDOM / scales.size(); i++)
            begin
                burst = (i % 80) < 25;
                send_pixel(rand_row(fs), burst);
            end
        end
        pix_ch.valid <= 0;
        wait (hsl_expected.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        $display("%0d pixels over %0d depth scales incl. 0, 128 and 255, clamped inputs, gray",
                 pixels_sent, scales.size());
        $display("%0d results checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("rgb_to_hsl_converter_core regression: pass");
        else
            $display("rgb_to_hsl_converter_core regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
